/* hdl/gtp_pkg.sv */
// Shared types, widths and constants for the go-to-point heading controller.
package gtp_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int STG_W         = $clog2(TABLE_LEN);

    localparam int XW = 28;
    localparam int ZW = 28;

    localparam int POS_W  = 16;
    localparam int HDG_W  = 11;
    localparam int PAR_W  = 15;
    localparam int GUARD  = 8;

    localparam int K_W        = 30;
    localparam int PROD_W     = (XW - 1) + K_W;
    localparam int DIST_SHIFT = 38;
    localparam int DIST_W     = PROD_W + 1 - DIST_SHIFT;
    localparam int SP_W       = PAR_W + DIST_W;

    localparam int ANG_SHIFT = 16;
    localparam int ANG_W     = 11;

    localparam logic signed [ZW-1:0] HALF_PI_Q = ZW'(26353589);
    localparam logic [K_W-1:0]       GAIN_K    = K_W'(652032874);

    localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
        ZW'(13176795), ZW'(7778716), ZW'(4110060), ZW'(2086331),
        ZW'(1047214),  ZW'(524117),  ZW'(262123),  ZW'(131069),
        ZW'(65536),    ZW'(32768),   ZW'(16384),   ZW'(8192),
        ZW'(4096),     ZW'(2048),    ZW'(1024),    ZW'(512),
        ZW'(256),      ZW'(128),     ZW'(64),      ZW'(32),
        ZW'(16),       ZW'(8),       ZW'(4),       ZW'(2)
    };

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_X    = 3'd0,
        REG_TARGET_Y    = 3'd1,
        REG_GAIN        = 3'd2,
        REG_MAX_SPEED   = 3'd3,
        REG_ARRIVE_RAD  = 3'd4,
        REG_HDG_TOL     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
        logic [PAR_W-1:0]        gain;
        logic [PAR_W-1:0]        max_speed;
        logic [PAR_W-1:0]        arrive_radius;
        logic [PAR_W-1:0]        heading_tolerance;
    } cfg_t;

    typedef struct packed {
        logic signed [XW-1:0]    x;
        logic signed [XW-1:0]    y;
        logic signed [ZW-1:0]    z;
        logic signed [HDG_W-1:0] hd;
    } cordic_t;

endpackage

/* hdl/gtp_cordic_cell.sv */
// One CORDIC vectoring micro-rotation cell with its own request slot.
module gtp_cordic_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [gtp_pkg::STG_W-1:0] stage_idx,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  gtp_pkg::cordic_t       in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output gtp_pkg::cordic_t       out_data
);
    import gtp_pkg::*;

    logic              valid_reg;
    cordic_t           data_reg;
    cordic_t           data_next;
    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] ang;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        x_in = in_data.x;
        y_in = in_data.y;
        z_in = in_data.z;
        xs   = x_in >>> stage_idx;
        ys   = y_in >>> stage_idx;
        ang  = ATAN_TAB[stage_idx];
        data_next.hd = in_data.hd;
        if (!y_in[XW-1]) begin
            data_next.x = x_in + ys;
            data_next.y = y_in - xs;
            data_next.z = z_in + ang;
        end else begin
            data_next.x = x_in - ys;
            data_next.y = y_in + xs;
            data_next.z = z_in - ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* hdl/gtp_post.sv */
// Gain correction, heading error and speed/turn command pipeline.
module gtp_post (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  gtp_pkg::cfg_t              cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  gtp_pkg::cordic_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gtp_pkg::PAR_W-1:0]  speed,
    output logic [gtp_pkg::ANG_W-1:0]  turn
);
    import gtp_pkg::*;

    // stage A: gain multiply, heading error
    logic              va_reg;
    logic              rdy_a;
    logic [PROD_W-1:0] prod_a_reg;
    logic [ANG_W-1:0]  ang_a_reg;
    logic [XW-2:0]     xc;
    logic [PROD_W-1:0] prod_next;
    logic signed [ZW:0] hd_sh;
    logic signed [ZW:0] err;
    logic [ZW:0]       aerr;
    logic [ZW+1:0]     rsum;
    logic [ZW+1-ANG_SHIFT:0] q;
    logic [ANG_W-1:0]  ang_next;

    // stage B: rounded distance
    logic              vb_reg;
    logic              rdy_b;
    logic [DIST_W-1:0] dist_b_reg;
    logic [ANG_W-1:0]  ang_b_reg;
    logic [PROD_W:0]   dsum;

    // stage C: speed product, decisions
    logic              vc_reg;
    logic              rdy_c;
    logic [SP_W-1:0]   sprod_c_reg;
    logic [ANG_W-1:0]  ang_c_reg;
    logic              move_c_reg;
    logic              turn_c_reg;

    // stage D: output register
    logic              vd_reg;
    logic              rdy_d;
    logic [PAR_W-1:0]  speed_reg;
    logic [ANG_W-1:0]  turn_reg;
    logic [SP_W:0]     ssum;
    logic [SP_W-8:0]   sp;
    logic [PAR_W-1:0]  sp_sat;
    logic [PAR_W-1:0]  speed_next;
    logic [ANG_W-1:0]  turn_next;

    assign rdy_d     = !vd_reg || out_ready;
    assign rdy_c     = !vc_reg || rdy_d;
    assign rdy_b     = !vb_reg || rdy_c;
    assign rdy_a     = !va_reg || rdy_b;
    assign in_ready  = rdy_a;
    assign out_valid = vd_reg;
    assign speed     = speed_reg;
    assign turn      = turn_reg;

    always_comb begin
        xc        = in_data.x[XW-1] ? '0 : in_data.x[XW-2:0];
        prod_next = PROD_W'(xc) * PROD_W'(GAIN_K);
        hd_sh     = {{(ZW+1-HDG_W-ANG_SHIFT){in_data.hd[HDG_W-1]}}, in_data.hd,
                     {ANG_SHIFT{1'b0}}};
        err       = {in_data.z[ZW-1], in_data.z} - hd_sh;
        aerr      = err[ZW] ? (ZW+1)'(-err) : (ZW+1)'(err);
        rsum      = {1'b0, aerr} + (ZW+2)'(1 << (ANG_SHIFT - 1));
        q         = rsum[ZW+1:ANG_SHIFT];
        ang_next  = (q > {{(ZW+2-ANG_SHIFT-ANG_W){1'b0}}, {ANG_W{1'b1}}})
                    ? {ANG_W{1'b1}} : q[ANG_W-1:0];
    end

    assign dsum = {1'b0, prod_a_reg} + (PROD_W+1)'(64'd1 << (DIST_SHIFT - 1));

    always_comb begin
        ssum   = {1'b0, sprod_c_reg} + (SP_W+1)'(128);
        sp     = ssum[SP_W:8];
        sp_sat = (sp > (SP_W-7)'(cfg.max_speed)) ? cfg.max_speed : sp[PAR_W-1:0];
        speed_next = '0;
        turn_next  = '0;
        if (move_c_reg) begin
            if (turn_c_reg) begin
                turn_next = ang_c_reg;
            end else begin
                speed_next = sp_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (rdy_a) va_reg <= in_valid;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
            if (rdy_d) vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a && in_valid) begin
            prod_a_reg <= prod_next;
            ang_a_reg  <= ang_next;
        end
        if (rdy_b && va_reg) begin
            dist_b_reg <= dsum[PROD_W:DIST_SHIFT];
            ang_b_reg  <= ang_a_reg;
        end
        if (rdy_c && vb_reg) begin
            sprod_c_reg <= SP_W'(cfg.gain) * SP_W'(dist_b_reg);
            ang_c_reg   <= ang_b_reg;
            move_c_reg  <= dist_b_reg > DIST_W'(cfg.arrive_radius);
            turn_c_reg  <= PAR_W'(ang_b_reg) > cfg.heading_tolerance;
        end
        if (rdy_d && vc_reg) begin
            speed_reg <= speed_next;
            turn_reg  <= turn_next;
        end
    end

endmodule

/* hdl/go_to_point_heading_controller.sv */
// Path from request accept to m_tvalid: pre-rotation register, CORDIC cell chain, post stages A to D.
// Throughput: one request per cycle while m_tready is high; each CORDIC cell and post stage holds one request.
// Backpressure collapses bubbles: a stage takes new data whenever it is empty or drains.
// Reset: synchronous active-low aresetn clears all valid flags and loads register defaults.
// Top level: config registers, pre-rotation stage, CORDIC cell chain, post pipeline.
module go_to_point_heading_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [47:0]                       s_tdata,   // pos_x, pos_y, heading
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // linear_speed, turn_rate
    input  logic                              cfg_wr_en,
    input  logic [gtp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gtp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import gtp_pkg::*;

    cfg_t    cfg_reg;
    logic    pre_valid_reg;
    cordic_t pre_reg;
    cordic_t pre_next;

    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [HDG_W-1:0] heading;
    logic signed [POS_W:0]   dx;
    logic signed [POS_W:0]   dy;
    logic signed [XW-1:0]    x0;
    logic signed [XW-1:0]    y0;

    logic    chain_valid [CORDIC_STAGES+1];
    logic    chain_ready [CORDIC_STAGES+1];
    cordic_t chain_data  [CORDIC_STAGES+1];

    logic [PAR_W-1:0] speed;
    logic [ANG_W-1:0] turn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_x          <= POS_W'(256);
            cfg_reg.target_y          <= POS_W'(256);
            cfg_reg.gain              <= PAR_W'(256);
            cfg_reg.max_speed         <= PAR_W'(768);
            cfg_reg.arrive_radius     <= PAR_W'(26);
            cfg_reg.heading_tolerance <= PAR_W'(26);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TARGET_X:   cfg_reg.target_x          <= cfg_wdata;
                REG_TARGET_Y:   cfg_reg.target_y          <= cfg_wdata;
                REG_GAIN:       cfg_reg.gain              <= cfg_wdata[PAR_W-1:0];
                REG_MAX_SPEED:  cfg_reg.max_speed         <= cfg_wdata[PAR_W-1:0];
                REG_ARRIVE_RAD: cfg_reg.arrive_radius     <= cfg_wdata[PAR_W-1:0];
                REG_HDG_TOL:    cfg_reg.heading_tolerance <= cfg_wdata[PAR_W-1:0];
                default: ;
            endcase
        end
    end

    // pre-rotation into the right half-plane
    always_comb begin
        pos_x   = s_tdata[POS_W-1:0];
        pos_y   = s_tdata[2*POS_W-1:POS_W];
        heading = s_tdata[2*POS_W+HDG_W-1:2*POS_W];
        dx = {cfg_reg.target_x[POS_W-1], cfg_reg.target_x} - {pos_x[POS_W-1], pos_x};
        dy = {cfg_reg.target_y[POS_W-1], cfg_reg.target_y} - {pos_y[POS_W-1], pos_y};
        x0 = {{(XW-POS_W-1-GUARD){dx[POS_W]}}, dx, {GUARD{1'b0}}};
        y0 = {{(XW-POS_W-1-GUARD){dy[POS_W]}}, dy, {GUARD{1'b0}}};
        pre_next.hd = heading;
        if (x0[XW-1]) begin
            if (!y0[XW-1]) begin
                pre_next.x = y0;
                pre_next.y = -x0;
                pre_next.z = HALF_PI_Q;
            end else begin
                pre_next.x = -y0;
                pre_next.y = x0;
                pre_next.z = -HALF_PI_Q;
            end
        end else begin
            pre_next.x = x0;
            pre_next.y = y0;
            pre_next.z = '0;
        end
    end

    assign s_tready = !pre_valid_reg || chain_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (s_tready) begin
            pre_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            pre_reg <= pre_next;
        end
    end

    assign chain_valid[0] = pre_valid_reg;
    assign chain_data[0]  = pre_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        gtp_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (STG_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    gtp_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (chain_valid[CORDIC_STAGES]),
        .in_ready  (chain_ready[CORDIC_STAGES]),
        .in_data   (chain_data[CORDIC_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .speed     (speed),
        .turn      (turn)
    );

    assign m_tdata = {{(32-PAR_W-ANG_W){1'b0}}, turn, speed};

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (speed == '0 || turn == '0))
        else $error("speed and turn both commanded");

    a_speed_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (speed <= cfg_reg.max_speed))
        else $error("linear speed above limit");

    a_turn_tol: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && turn != '0) |-> (PAR_W'(turn) > cfg_reg.heading_tolerance))
        else $error("turn issued within heading tolerance");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage empty");

endmodule

/* verif/tb_go_to_point_heading_controller.sv */
// Self-checking testbench for the go-to-point heading controller: directed and random poses.
module tb_go_to_point_heading_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import gtp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam longint ANGLE_HALF_PI = 26353589;
    localparam longint CORR_K_Q30    = 652032874;
    localparam int     HOLD_CYCLES   = 300;

    localparam longint ARCTAN_Q [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct {
        logic [PAR_W-1:0] linear_speed;
        logic [ANG_W-1:0] turn_rate;
    } steer_cmd_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;   // pos_x, pos_y, heading
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;   // linear_speed, turn_rate
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cfg_t       goal_cfg;
    steer_cmd_t cmd_expected_q[$];
    int         mismatch_cnt;
    int         send_idle_pct;
    int         recv_idle_pct;
    logic       hold_pending;
    int         hold_left;

    go_to_point_heading_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic steer_cmd_t predict_command(input logic signed [POS_W-1:0] px,
                                                   input logic signed [POS_W-1:0] py,
                                                   input logic signed [HDG_W-1:0] hd);
        longint vx, vy, ang, t, sx, sy, dist_q, err, ang_q, speed;
        steer_cmd_t cmd;
        vx = (longint'(goal_cfg.target_x) - longint'(px)) * 256;
        vy = (longint'(goal_cfg.target_y) - longint'(py)) * 256;
        ang = 0;
        if (vx < 0) begin
            t = vx;
            if (vy >= 0) begin
                vx = vy;
                vy = -t;
                ang = ANGLE_HALF_PI;
            end else begin
                vx = -vy;
                vy = t;
                ang = -ANGLE_HALF_PI;
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
                vx = vx + sy;
                vy = vy - sx;
                ang = ang + ARCTAN_Q[i];
            end else begin
                vx = vx - sy;
                vy = vy + sx;
                ang = ang - ARCTAN_Q[i];
            end
        end
        if (vx < 0)
            vx = 0;
        dist_q = (vx * CORR_K_Q30 + (64'sd1 <<< 37)) >>> 38;
        err = ang - longint'(hd) * 65536;
        if (err < 0)
            err = -err;
        ang_q = (err + 32768) >>> 16;
        if (ang_q > 2047)
            ang_q = 2047;
        cmd.linear_speed = '0;
        cmd.turn_rate = '0;
        if (dist_q > longint'(goal_cfg.arrive_radius)) begin
            if (ang_q > longint'(goal_cfg.heading_tolerance)) begin
                cmd.turn_rate = ang_q[ANG_W-1:0];
            end else begin
                speed = (longint'(goal_cfg.gain) * dist_q + 128) >>> 8;
                if (speed > longint'(goal_cfg.max_speed))
                    speed = longint'(goal_cfg.max_speed);
                cmd.linear_speed = speed[PAR_W-1:0];
            end
        end
        return cmd;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    always @(posedge aclk) begin : result_check
        steer_cmd_t got;
        steer_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.linear_speed = m_tdata[PAR_W-1:0];
            got.turn_rate = m_tdata[PAR_W +: ANG_W];
            if (cmd_expected_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result speed=%0d turn=%0d",
                                        got.linear_speed, got.turn_rate));
            end else begin
                want = cmd_expected_q.pop_front();
                if (got.linear_speed !== want.linear_speed)
                    flag_mismatch($sformatf("linear_speed exp=%0d got=%0d",
                                            want.linear_speed, got.linear_speed));
                if (got.turn_rate !== want.turn_rate)
                    flag_mismatch($sformatf("turn_rate exp=%0d got=%0d",
                                            want.turn_rate, got.turn_rate));
            end
        end
    end

    // result-side ready: random stalls, plus a long hold-off on request
    initial begin
        m_tready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_pending) begin
                hold_pending <= 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_pose(input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] py,
                             input logic signed [HDG_W-1:0] hd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, hd, py, px};
        do @(posedge aclk); while (!s_tready);
        cmd_expected_q.push_back(predict_command(px, py, hd));
    endtask

    // mostly poses aimed near the bearing, some near the goal, rest noise
    task automatic send_random_pose();
        logic signed [POS_W-1:0] px, py;
        logic signed [HDG_W-1:0] hd;
        int kind, dx, dy, h;
        kind = $urandom_range(99);
        px = POS_W'($urandom());
        py = POS_W'($urandom());
        hd = HDG_W'($urandom());
        if (kind < 20) begin
            px = POS_W'(int'(goal_cfg.target_x) + int'($urandom_range(128)) - 64);
            py = POS_W'(int'(goal_cfg.target_y) + int'($urandom_range(128)) - 64);
        end
        if (kind < 65) begin
            dx = int'(goal_cfg.target_x) - int'(px);
            dy = int'(goal_cfg.target_y) - int'(py);
            h = $rtoi($atan2(real'(dy), real'(dx)) * 256.0) + int'($urandom_range(64)) - 32;
            if (h > 1023)
                h = 1023;
            if (h < -1024)
                h = -1024;
            hd = HDG_W'(h);
        end
        send_pose(px, py, hd);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (cmd_expected_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_TARGET_X:   goal_cfg.target_x = data;
            REG_TARGET_Y:   goal_cfg.target_y = data;
            REG_GAIN:       goal_cfg.gain = data[PAR_W-1:0];
            REG_MAX_SPEED:  goal_cfg.max_speed = data[PAR_W-1:0];
            REG_ARRIVE_RAD: goal_cfg.arrive_radius = data[PAR_W-1:0];
            REG_HDG_TOL:    goal_cfg.heading_tolerance = data[PAR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_goal(input logic [15:0] tx, input logic [15:0] ty,
                              input logic [15:0] gn, input logic [15:0] ms,
                              input logic [15:0] ar, input logic [15:0] ht);
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
        write_reg(REG_GAIN, gn);
        write_reg(REG_MAX_SPEED, ms);
        write_reg(REG_ARRIVE_RAD, ar);
        write_reg(REG_HDG_TOL, ht);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_random_goal();
        logic [15:0] tol;
        tol = {1'($urandom()), 15'($urandom_range(120))};
        if ($urandom_range(3) == 0)
            tol = 16'($urandom());
        write_goal(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                   {1'($urandom()), 15'($urandom_range(800))}, tol);
    endtask

    task automatic test_reset_defaults();
        send_pose(16'sd256, 16'sd256, 11'sd0);
        send_pose(16'sd0, 16'sd0, 11'sd201);
        send_pose(16'sd0, 16'sd0, 11'sd0);
        send_pose(16'sd512, 16'sd0, 11'sd603);
        send_pose(16'sd512, 16'sd512, -11'sd603);
        send_pose(16'sd512, 16'sd512, 11'sd603);
        send_pose(-16'sd32768, -16'sd32768, 11'sd201);
        send_pose(16'sd32767, 16'sd32767, -11'sd1024);
        send_pose(16'sd256, 16'sd250, 11'sd1023);
        send_pose(16'sd0, 16'sd256, 11'sd0);
        send_pose(16'sd512, 16'sd256, 11'sd805);
        send_pose(16'sd256, 16'sd0, 11'sd402);
        send_pose(16'sd256, 16'sd512, -11'sd402);
        wait_for_results();
    endtask

    task automatic test_config_extremes();
        write_goal(16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000);
        send_pose(-16'sd32768, 16'sd32767, -11'sd201);
        send_pose(16'sd32767, -16'sd32768, 11'sd0);
        send_pose(16'sd32767, -16'sd32767, 11'sd402);
        send_pose(-16'sd32768, -16'sd32768, 11'sd0);
        wait_for_results();
        write_goal(16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF, 16'hFFFF);
        send_pose(16'sd32767, -16'sd32768, 11'sd0);
        send_pose(-16'sd32768, 16'sd0, 11'sd1023);
        wait_for_results();
        write_reg(REG_SPARE_A, 16'h1234);
        write_reg(REG_SPARE_B, 16'hFFFF);
        cfg_wr_en <= 1'b0;
        send_pose(16'sd32767, -16'sd32768, -11'sd1024);
        send_pose(16'sd100, 16'sd100, 11'sd0);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int s = 0; s < 3; s++) begin
            wait_for_results();
            load_random_goal();
            repeat (n_items / 3) send_random_pose();
        end
        wait_for_results();
    endtask

    task automatic test_backpressure_fill();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_random_goal();
        hold_pending <= 1'b1;
        repeat (80) send_random_pose();
        wait_for_results();
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        hold_pending <= 1'b0;
        mismatch_cnt = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        goal_cfg.target_x = 16'sd256;
        goal_cfg.target_y = 16'sd256;
        goal_cfg.gain = 15'd256;
        goal_cfg.max_speed = 15'd768;
        goal_cfg.arrive_radius = 15'd26;
        goal_cfg.heading_tolerance = 15'd26;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_config_extremes();
        test_random_traffic(360, 24, 73);
        test_random_traffic(360, 73, 24);
        test_random_traffic(330, 0, 0);
        test_backpressure_fill();

        wait_for_results();
        repeat (40) @(posedge aclk);
        if (mismatch_cnt == 0 && cmd_expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
